// File: rtl/spr_pkg.sv
// Package for the slotted page record manager.
// Sizes, op and status codes, request, result and memory port types. No dependencies.
package spr_pkg;
    localparam int DATA_AREA_BYTES = 4092;
    localparam int DESC_BYTES      = 14;
    localparam int MAX_RECORDS     = 256;
    localparam int SLOT_W          = 8;
    localparam int COUNT_W         = 9;
    localparam int BYTES_W         = 13;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [11:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [7:0]  slot_index;
        logic [11:0] record_offset;
        logic [11:0] record_length;
        logic [11:0] move_source;
        logic [11:0] move_bytes;
        logic [11:0] free_space;
        logic [11:0] data_end;
        logic [8:0]  record_count;
        logic        dirty;
    } rsp_t;

    // Descriptor memory port bundle
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [63:0]       wkey;
        logic [12:0]       wlen;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;
endpackage

// File: rtl/spr_if.sv
// Valid/ready channel interface carrying one item.
// Depends on spr_pkg for the payload types.
interface spr_req_if;
    import spr_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spr_rsp_if;
    import spr_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/spr_desc_mem.sv
// Descriptor table: key and length per slot, one write and one read port.
// Registered read. Depends on spr_pkg.
module spr_desc_mem
    import spr_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [63:0] rkey,
    output logic [12:0] rlen
);
    logic [63:0] key_mem [MAX_RECORDS];
    logic [12:0] len_mem [MAX_RECORDS];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            key_mem[req.waddr] <= req.wkey;
            len_mem[req.waddr] <= req.wlen;
        end
        rkey <= key_mem[req.raddr];
        rlen <= len_mem[req.raddr];
    end
endmodule

// File: rtl/spr_ctrl.sv
// Operation sequencer: scans descriptors, shifts on delete or resized update, appends.
// Depends on spr_pkg and the descriptor memory bundle.
module spr_ctrl
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data,
    output mem_req_t    mreq,
    input  logic [63:0] rkey,
    input  logic [12:0] rlen
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_APPEND, S_DONE} state_t;

    state_t              state_reg;
    req_t                req_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [BYTES_W-1:0]  dend_reg;
    logic [BYTES_W-1:0]  free_reg;
    logic                dirty_reg;
    logic [COUNT_W-1:0]  idx_reg;      // slot being read this cycle
    logic                rd_vld_reg;   // memory data valid for idx_reg-1
    logic [BYTES_W-1:0]  off_reg;
    logic [BYTES_W-1:0]  hlen_reg;
    logic [COUNT_W-1:0]  sh_reg;       // shift destination slot
    rsp_t                rsp_reg;      // result under construction
    rsp_t                out_reg;      // result waiting on the output channel
    logic                out_vld_reg;

    logic [COUNT_W-1:0]  prev_idx;
    logic [BYTES_W-1:0]  need;
    logic                fits;
    logic [BYTES_W-1:0]  src_sum;
    rsp_t                rsp_fin;

    assign prev_idx = idx_reg - COUNT_W'(1);
    assign need     = BYTES_W'(req_reg.length) + BYTES_W'(DESC_BYTES);
    assign fits     = (count_reg < COUNT_W'(MAX_RECORDS)) && (free_reg >= need);
    assign src_sum  = off_reg + hlen_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Final result: record fields plus page state after the operation
    always_comb
    begin
        rsp_fin              = rsp_reg;
        rsp_fin.free_space   = free_reg[11:0];
        rsp_fin.data_end     = dend_reg[11:0];
        rsp_fin.record_count = count_reg;
        rsp_fin.dirty        = dirty_reg;
    end

    // Memory port: read address is the scan/shift index, write on shift/append
    always_comb
    begin
        mreq.raddr = idx_reg[SLOT_W-1:0];
        mreq.we    = 1'b0;
        mreq.waddr = sh_reg[SLOT_W-1:0];
        mreq.wkey  = rkey;
        mreq.wlen  = rlen;
        if (state_reg == S_SHIFT && rd_vld_reg)
        begin
            mreq.we = 1'b1;
        end
        else if (state_reg == S_APPEND && fits)
        begin
            mreq.we    = 1'b1;
            mreq.waddr = count_reg[SLOT_W-1:0];
            mreq.wkey  = req_reg.key;
            mreq.wlen  = BYTES_W'(req_reg.length);
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            req_reg     <= '0;
            count_reg   <= '0;
            dend_reg    <= '0;
            free_reg    <= BYTES_W'(DATA_AREA_BYTES);
            dirty_reg   <= 1'b1;
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            idx_reg     <= '0;
            off_reg     <= '0;
            hlen_reg    <= '0;
            sh_reg      <= '0;
            rsp_reg     <= '0;
            out_reg     <= '0;
        end
        else
        begin
            // Pending result taken; S_DONE reloads it itself
            if (out_vld_reg && out_ready && state_reg != S_DONE)
                out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg    <= in_data;
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        off_reg    <= '0;
                        hlen_reg   <= '0;
                        rsp_reg    <= '0;
                        if (in_data.op == OP_CLEAR)
                        begin
                            count_reg <= '0;
                            dend_reg  <= '0;
                            free_reg  <= BYTES_W'(DATA_AREA_BYTES);
                            dirty_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else if (in_data.op inside {OP_LOOKUP, OP_WRITE, OP_DELETE,
                                                    OP_UPDATE})
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    // Compare slot idx-1 (data arrived), advance read address
                    if (rd_vld_reg && rkey == req_reg.key)
                    begin
                        hlen_reg  <= rlen;
                        sh_reg    <= prev_idx;
                        rd_vld_reg <= 1'b0;
                        rsp_reg.found         <= 1'b1;
                        rsp_reg.slot_index    <= prev_idx[SLOT_W-1:0];
                        rsp_reg.record_offset <= off_reg[11:0];
                        rsp_reg.record_length <= rlen[11:0];
                        if (req_reg.op == OP_LOOKUP)
                            state_reg <= S_DONE;
                        else if (req_reg.op == OP_WRITE)
                            state_reg <= S_APPEND;
                        else if (req_reg.op == OP_UPDATE
                                 && rlen == BYTES_W'(req_reg.length))
                        begin
                            dirty_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // idx_reg already points at slot hit+1
                            state_reg  <= S_SHIFT;
                        end
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        rd_vld_reg <= 1'b0;
                        if (req_reg.op == OP_WRITE)
                            state_reg <= S_APPEND;
                        else
                        begin
                            rsp_reg.status <= ST_NOTFOUND;
                            state_reg      <= S_DONE;
                        end
                    end
                    else
                    begin
                        if (rd_vld_reg)
                            off_reg <= off_reg + rlen;
                        idx_reg    <= idx_reg + COUNT_W'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    // Copy slot idx-1 down to sh_reg
                    if (rd_vld_reg)
                        sh_reg <= sh_reg + COUNT_W'(1);
                    if (idx_reg >= count_reg)
                    begin
                        if (!rd_vld_reg || sh_reg + COUNT_W'(2) >= count_reg)
                        begin
                            rd_vld_reg <= 1'b0;
                            count_reg  <= count_reg - COUNT_W'(1);
                            dend_reg   <= (dend_reg >= hlen_reg) ? dend_reg - hlen_reg : '0;
                            free_reg   <= free_reg + hlen_reg + BYTES_W'(DESC_BYTES);
                            dirty_reg  <= 1'b1;
                            rsp_reg.move_source <= src_sum[11:0];
                            rsp_reg.move_bytes  <= (dend_reg >= src_sum)
                                                   ? 12'(dend_reg - src_sum) : '0;
                            state_reg <= (req_reg.op == OP_UPDATE) ? S_APPEND : S_DONE;
                        end
                        else
                            rd_vld_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg    <= idx_reg + COUNT_W'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_APPEND:
                begin
                    if (fits)
                    begin
                        rsp_reg.slot_index    <= count_reg[SLOT_W-1:0];
                        rsp_reg.record_offset <= dend_reg[11:0];
                        rsp_reg.record_length <= req_reg.length;
                        count_reg <= count_reg + COUNT_W'(1);
                        dend_reg  <= dend_reg + BYTES_W'(req_reg.length);
                        free_reg  <= free_reg - need;
                        dirty_reg <= 1'b1;
                    end
                    else
                    begin
                        rsp_reg.status <= ST_NOSPACE;
                        if (req_reg.op == OP_WRITE)
                        begin
                            rsp_reg.slot_index    <= '0;
                            rsp_reg.record_offset <= '0;
                            rsp_reg.record_length <= '0;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_vld_reg || out_ready)
                    begin
                        out_reg     <= rsp_fin;
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/slotted_page_record_manager_core.sv
// Slotted page record manager top level.
// Items are handled one at a time, one descriptor read per cycle; the next item
// is accepted once the result is loaded into the output register and the
// sequencer is back in S_IDLE.
// Result sits in its own register; a stalled result holds the next one in S_DONE.
// Reset (rst_n, async low): empty page, free = area size, dirty set.
module slotted_page_record_manager_core
    import spr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    spr_req_if.sink   in_ch,
    spr_rsp_if.source out_ch
);
    mem_req_t    mreq;
    logic [63:0] rkey;
    logic [12:0] rlen;

    // Descriptor storage
    spr_desc_mem u_mem (
        .clk  (clk),
        .req  (mreq),
        .rkey (rkey),
        .rlen (rlen)
    );

    // Sequencer
    spr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .mreq      (mreq),
        .rkey      (rkey),
        .rlen      (rlen)
    );

    // Count never exceeds the table
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.record_count <= 9'(MAX_RECORDS))
        else $error("record count overflow");

    // Not-found results never have the found flag set
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.status == ST_NOTFOUND) |-> !out_ch.data.found)
        else $error("not found with found flag");

    // No new item accepted while one is in flight
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("accepted during busy");
endmodule
